// File: hw/rtl/ctkd_pkg.sv
`timescale 1ns / 1ps

package ctkd_pkg;

	localparam int MAX_KEYS     = 16;
	localparam int KEY_W        = 4;
	localparam int KCNT_W       = 5;
	localparam int COUNT_W      = 17;
	localparam int MASK_W       = 16;

	// group length is a power of two: average is a plain shift
	localparam int SPG_LOG2          = 4;
	localparam int SAMPLES_PER_GROUP = 1 << SPG_LOG2;
	localparam int IDX_W             = (SPG_LOG2 > 0) ? SPG_LOG2 : 1;
	localparam int SUM_W             = COUNT_W + SPG_LOG2;

	localparam logic [KCNT_W-1:0]  KEY_COUNT_RST = KCNT_W'(MAX_KEYS);
	localparam logic [COUNT_W-1:0] TIMEOUT_RST   = COUNT_W'(100000);
	localparam logic [IDX_W-1:0]   IDX_LAST      = IDX_W'(SAMPLES_PER_GROUP - 1);

	// configuration register indexes
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = COUNT_W;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_COUNT = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT   = 1'd1;

	// input stream: tdata = {pad, charge_count, key}; tuser = cmd
	localparam int S_TDATA_W = 24;
	localparam int S_TUSER_W = 1;
	localparam logic CMD_MEASURE   = 1'b0;
	localparam logic CMD_CALIBRATE = 1'b1;

	// output stream: tdata = {pad, pressed_mask, pressed, average, key_out}
	localparam int M_TDATA_W   = 40;
	localparam int M_TUSER_W   = 1;
	localparam int M_AVG_LSB   = KEY_W;
	localparam int M_PRESS_BIT = KEY_W + COUNT_W;
	localparam int M_MASK_LSB  = KEY_W + COUNT_W + 1;

	typedef struct packed {
		logic [COUNT_W-1:0] baseline;
		logic [IDX_W-1:0]   idx;
		logic [SUM_W-1:0]   sum;
	} entry_t;

endpackage

// File: hw/rtl/capacitive_touch_key_detector.sv
`timescale 1ns / 1ps
// A group's last sample reaches m_tvalid via the memory read, then the update.
// Throughput: one sample per cycle while the output is not stalled; the write-back
// register forwards the key just updated, so a key's back-to-back samples do not stall.
// Per-key sum, count and baseline live in one 16-entry synchronous memory.
// Reset (arst_n low): config registers to defaults, pressed mask and all per-key
// valid bits cleared (an unwritten key reads as zero), pipeline emptied.

module capacitive_touch_key_detector (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [ctkd_pkg::S_TDATA_W-1:0]    s_tdata,   // key[3:0], charge_count[20:4]
	input  logic [ctkd_pkg::S_TUSER_W-1:0]    s_tuser,   // cmd[0]
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [ctkd_pkg::M_TDATA_W-1:0]    m_tdata,   // key_out[3:0], average[20:4],
	                                                     // pressed[21], pressed_mask[37:22]
	output logic [ctkd_pkg::M_TUSER_W-1:0]    m_tuser,   // was_calibration[0]
	output logic                              m_tlast,   // scan_done
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [ctkd_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [ctkd_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import ctkd_pkg::*;

	logic [KCNT_W-1:0]  key_count_q;
	logic [COUNT_W-1:0] timeout_q;
	logic [KCNT_W-1:0]  keys_used;

	logic               in_cmd;
	logic [KEY_W-1:0]   in_key;
	logic [COUNT_W-1:0] in_count;
	logic [COUNT_W-1:0] in_clamped;
	logic               in_use;
	logic               s_fire;

	logic               valid_s1;
	logic               cmd_s1;
	logic [KEY_W-1:0]   key_s1;
	logic [COUNT_W-1:0] count_s1;

	entry_t             mem_q [MAX_KEYS];
	entry_t             rd_q;
	logic [KEY_W-1:0]   rd_addr;
	logic [MAX_KEYS-1:0] vld_q;

	logic               fwd_valid_q;
	logic [KEY_W-1:0]   fwd_key_q;
	entry_t             fwd_data_q;

	entry_t             cur;
	entry_t             nxt;
	logic [SUM_W-1:0]   new_sum;
	logic [COUNT_W-1:0] avg;
	logic [COUNT_W:0]   thr;
	logic               done;
	logic               pressed;
	logic               s1_adv;
	logic               wr_en;
	logic [MASK_W-1:0]  mask_q;
	logic [MASK_W-1:0]  mask_nxt;
	logic               scan_last;

	logic               out_valid_q;
	logic [KEY_W-1:0]   out_key_q;
	logic [COUNT_W-1:0] out_avg_q;
	logic               out_pressed_q;
	logic [MASK_W-1:0]  out_mask_q;
	logic               out_cal_q;
	logic               out_last_q;

	// configuration
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_count_q <= KEY_COUNT_RST;
			timeout_q   <= TIMEOUT_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_KEY_COUNT: key_count_q <= cfg_data[KCNT_W-1:0];
				REG_TIMEOUT:   timeout_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	assign keys_used = (key_count_q > KCNT_W'(MAX_KEYS)) ? KCNT_W'(MAX_KEYS) : key_count_q;

	// input unpack
	assign in_key     = s_tdata[KEY_W-1:0];
	assign in_count   = s_tdata[KEY_W +: COUNT_W];
	assign in_cmd     = s_tuser[0];
	assign in_clamped = (in_count > timeout_q) ? timeout_q : in_count;
	assign in_use     = {1'b0, in_key} < keys_used;
	assign s_fire     = s_tvalid && s_tready;

	// s1 holds while its result cannot enter a full output register
	assign done    = valid_s1 && (cur.idx == IDX_LAST);
	assign s1_adv  = !(done && out_valid_q && !m_tready);
	assign s_tready = s1_adv;
	assign wr_en   = valid_s1 && s1_adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s1_adv) begin
			valid_s1 <= s_fire && in_use;
		end
	end

	always_ff @(posedge clk) begin
		if (s_fire) begin
			cmd_s1   <= in_cmd;
			key_s1   <= in_key;
			count_s1 <= in_clamped;
		end
	end

	// state memory, one read and one write port
	assign rd_addr = s_fire ? in_key : key_s1;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[key_s1] <= nxt;
		end
		rd_q <= mem_q[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q       <= '0;
			fwd_valid_q <= 1'b0;
		end else begin
			fwd_valid_q <= wr_en;
			if (wr_en) begin
				vld_q[key_s1] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		fwd_key_q  <= key_s1;
		fwd_data_q <= nxt;
	end

	// read data: last write-back wins over the memory, unwritten entries are zero
	always_comb begin
		if (fwd_valid_q && (fwd_key_q == key_s1)) begin
			cur = fwd_data_q;
		end else if (vld_q[key_s1]) begin
			cur = rd_q;
		end else begin
			cur = '0;
		end
	end

	assign new_sum = cur.sum + SUM_W'(count_s1);
	assign avg     = new_sum[SUM_W-1:SPG_LOG2];
	assign thr     = {1'b0, cur.baseline} + {2'b00, cur.baseline[COUNT_W-1:1]};
	assign pressed = (cmd_s1 == CMD_MEASURE) && ({1'b0, avg} > thr);
	assign scan_last = ({1'b0, key_s1} + KCNT_W'(1)) == keys_used;

	always_comb begin
		nxt      = cur;
		mask_nxt = mask_q;
		if (done) begin
			nxt.sum = '0;
			nxt.idx = '0;
			if (cmd_s1 == CMD_CALIBRATE) begin
				nxt.baseline = avg;
			end else begin
				mask_nxt[key_s1] = pressed;
			end
		end else begin
			nxt.sum = new_sum;
			nxt.idx = cur.idx + IDX_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= '0;
		end else if (wr_en) begin
			mask_q <= mask_nxt;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (wr_en && done) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en && done) begin
			out_key_q     <= key_s1;
			out_avg_q     <= avg;
			out_pressed_q <= pressed;
			out_mask_q    <= mask_nxt;
			out_cal_q     <= cmd_s1;
			out_last_q    <= scan_last;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {(M_TDATA_W - M_MASK_LSB - MASK_W)'(0), out_mask_q, out_pressed_q,
		out_avg_q, out_key_q};
	assign m_tuser  = out_cal_q;
	assign m_tlast  = out_last_q;

endmodule

// File: hw/rtl/ctkd_checker.sv
`timescale 1ns / 1ps

module ctkd_checker (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	input  logic                              s_tready,
	input  logic                              m_tvalid,
	input  logic                              m_tready,
	input  logic [ctkd_pkg::M_TDATA_W-1:0]    m_tdata,
	input  logic [ctkd_pkg::M_TUSER_W-1:0]    m_tuser,
	input  logic                              m_tlast
);
	import ctkd_pkg::*;

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
			&& $stable(m_tlast))
		else $error("output changed while stalled");

	// a new result needs a matching input transaction, registered through s1 first
	a_out_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
		else $error("result without a matching input transaction");

	// calibration results never report a press
	a_cal_no_press: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> !m_tdata[M_PRESS_BIT])
		else $error("pressed set on a calibration result");

	// measure result: the key's mask bit matches pressed
	a_mask_bit: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |->
			m_tdata[M_MASK_LSB + m_tdata[KEY_W-1:0]] == m_tdata[M_PRESS_BIT])
		else $error("pressed mask bit disagrees with pressed");

endmodule

bind capacitive_touch_key_detector ctkd_checker u_ctkd_checker (.*);
